// ----- rtl/xcq_pkg.sv -----
// Shared constants, palette tables and contrast function of the contrast-aware palette quantizer.
`timescale 1ns / 1ps

package xcq_pkg;

  localparam int unsigned SLOT_FIRST = 16;
  localparam int unsigned SLOT_COUNT = 240;
  localparam int unsigned GREY_FIRST = 232;
  localparam int unsigned LUMA_W     = 21;
  localparam int unsigned SUM_W      = 34;
  localparam int unsigned DIST_W     = 18;
  localparam int unsigned DIV_ROUND  = 5000;

  // Division by 10000 is a shift by 4 (10000 = 16 * 625) followed by a
  // multiply with ceil(2^40 / 625). The error term stays below one for any
  // 30-bit dividend, so the quotient is exact.
  localparam int unsigned DIV_SHIFT   = 4;
  localparam int unsigned RECIP_SHIFT = 40;
  localparam logic [30:0] RECIP_625   = 31'd1759218605;

  localparam logic [LUMA_W-1:0] EPS_Q20   = LUMA_W'(52429);
  localparam logic [LUMA_W-1:0] WHITE_Q20 = LUMA_W'(1048576);
  localparam logic [63:0]       ONE_Q30   = 64'd1 << 30;

  localparam logic [12:0] COEF_R = 13'd2126;
  localparam logic [12:0] COEF_G = 13'd7152;
  localparam logic [12:0] COEF_B = 13'd722;

  typedef logic [255:0][LUMA_W-1:0]     lin_tab_t;
  typedef logic [SLOT_COUNT-1:0][23:0]  rgb_tab_t;
  typedef logic [SLOT_COUNT-1:0][LUMA_W-1:0] luma_tab_t;
  typedef logic [SLOT_COUNT-1:0]        flag_tab_t;

  // Fifth power of a Q30 value, each product floored back to Q30.
  function automatic logic [63:0] fifth_pow(input logic [63:0] t);
    logic [63:0] p;
    p = t;
    for (int k = 0; k < 4; k++) begin
      p = (p * t) >> 30;
    end
    return p;
  endfunction

  // sRGB code to linear light in Q20, via a bitwise fifth-root search.
  function automatic logic [LUMA_W-1:0] lin_entry(input int unsigned c);
    logic [63:0] x;
    logic [63:0] q;
    logic [63:0] t;
    logic [63:0] v;
    logic [63:0] cand;
    if (c <= 10) begin
      return LUMA_W'((64'(c) * 64'd104857600 + 64'd164730) / 64'd329460);
    end
    x = ((64'(1000 * c + 14025) << 30) + 64'd134512) / 64'd269025;
    q = (x * x) >> 30;
    if (q >= ONE_Q30) begin
      t = ONE_Q30;
    end else begin
      t = 64'd0;
      for (int b = 29; b >= 0; b--) begin
        cand = t | (64'd1 << b);
        if (fifth_pow(cand) <= q) begin
          t = cand;
        end
      end
    end
    v = (q * t) >> 30;
    return LUMA_W'((v + 64'd512) >> 10);
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int c = 0; c < 256; c++) begin
      tab[c] = lin_entry(c);
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

  function automatic logic [7:0] cube_level(input int unsigned n);
    logic [7:0] lv;
    case (n)
      0:       lv = 8'd0;
      1:       lv = 8'd95;
      2:       lv = 8'd135;
      3:       lv = 8'd175;
      4:       lv = 8'd215;
      default: lv = 8'd255;
    endcase
    return lv;
  endfunction

  function automatic logic [23:0] slot_rgb(input int unsigned slot);
    logic [7:0] g;
    int unsigned n;
    if (slot >= GREY_FIRST) begin
      g = 8'(8 + 10 * (slot - GREY_FIRST));
      return {g, g, g};
    end
    n = slot - SLOT_FIRST;
    return {cube_level((n / 36) % 6), cube_level((n / 6) % 6), cube_level(n % 6)};
  endfunction

  function automatic logic [LUMA_W-1:0] luma_of(input logic [23:0] rgb);
    logic [63:0] s;
    s = 64'd2126 * 64'(LIN_TAB[rgb[23:16]]) + 64'd7152 * 64'(LIN_TAB[rgb[15:8]])
      + 64'd722 * 64'(LIN_TAB[rgb[7:0]]);
    return LUMA_W'((s + 64'd5000) / 64'd10000);
  endfunction

  // Passes when (Lhi + 0.05) >= 7 * (Llo + 0.05), all in Q20.
  function automatic logic contrast_ok(input logic [LUMA_W-1:0] la,
                                       input logic [LUMA_W-1:0] lb);
    logic [LUMA_W-1:0] hi;
    logic [LUMA_W-1:0] lo;
    logic [23:0] hi_e;
    logic [23:0] lo_e;
    hi   = (la >= lb) ? la : lb;
    lo   = (la >= lb) ? lb : la;
    hi_e = 24'(hi) + 24'(EPS_Q20);
    lo_e = 24'(lo) + 24'(EPS_Q20);
    return hi_e >= ((lo_e << 3) - lo_e);
  endfunction

  function automatic rgb_tab_t build_rgb_tab();
    rgb_tab_t tab;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      tab[i] = slot_rgb(i + SLOT_FIRST);
    end
    return tab;
  endfunction

  function automatic luma_tab_t build_luma_tab();
    luma_tab_t tab;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      tab[i] = luma_of(slot_rgb(i + SLOT_FIRST));
    end
    return tab;
  endfunction

  function automatic flag_tab_t build_bg_tab();
    flag_tab_t tab;
    logic [LUMA_W-1:0] l;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      l = luma_of(slot_rgb(i + SLOT_FIRST));
      tab[i] = contrast_ok(l, '0) || contrast_ok(l, WHITE_Q20);
    end
    return tab;
  endfunction

  localparam rgb_tab_t  SLOT_RGB   = build_rgb_tab();
  localparam luma_tab_t SLOT_LUMA  = build_luma_tab();
  localparam flag_tab_t SLOT_BG_OK = build_bg_tab();

endpackage

// ----- rtl/xcq_if.sv -----
// Request and result channel interfaces of the contrast-aware palette quantizer.
`timescale 1ns / 1ps

interface xcq_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] target_color;
  logic [23:0] backdrop_color;
  logic        is_foreground;

  modport source (output valid, output target_color, output backdrop_color,
                  output is_foreground, input ready);
  modport sink   (input valid, input target_color, input backdrop_color,
                  input is_foreground, output ready);
endinterface

interface xcq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] palette_index;

  modport source (output valid, output palette_index, input ready);
  modport sink   (input valid, input palette_index, output ready);
endinterface

// ----- rtl/xterm256_contrast_quantizer.sv -----
// Top level of the contrast-aware 256-color palette quantizer.
`timescale 1ns / 1ps

// Usage:
// A request on in_chan carries a target color, a backdrop color and a
// foreground flag. The block answers each request with one palette slot in
// the range 16 to 255 on out_chan: the slot nearest to the target in squared
// RGB distance among those meeting a 7:1 contrast ratio (against the backdrop
// for foreground use, against black or white for background use).
// Both channels use a valid/ready handshake; a request is taken when valid and
// ready are high at a rising clock edge.
// Sequence: a foreground request first accumulates the backdrop luminance
// over the three channels through one shared multiplier, then divides by
// 10000 with a reciprocal multiply, then scans the 240 slots one candidate
// per cycle, and at last loads the result register. A background request
// skips the backdrop work. One request is worked on at a time; in_chan.ready
// returns in the same cycle that the loaded result appears on out_chan, so a
// new request is not taken before the last one is through the scan.
// A finished result waits in the output register; a new request can be taken
// while it waits. If the receiver stalls past the next scan, the block holds
// the second result and stays not ready until the first one is taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_chan.valid. No palette tables need filling after reset.
module xterm256_contrast_quantizer
  import xcq_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  xcq_in_if.sink    in_chan,
  xcq_out_if.source out_chan
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_SCAN,
    ST_DONE
  } state_t;

  localparam logic [7:0] LAST_IDX  = 8'(SLOT_COUNT - 1);

  state_t              state_r,       state_nxt;
  logic                out_valid_r,   out_valid_nxt;
  logic [7:0]          out_idx_r,     out_idx_nxt;
  logic [23:0]         target_r,      target_nxt;
  logic [23:0]         backdrop_r,    backdrop_nxt;
  logic                fg_r,          fg_nxt;
  logic [1:0]          ch_r,          ch_nxt;
  logic [SUM_W-1:0]    acc_r,         acc_nxt;
  logic [SUM_W-1:0]    num_r,         num_nxt;
  logic [7:0]          idx_r,         idx_nxt;
  logic [DIST_W-1:0]   best_cost_r,   best_cost_nxt;
  logic [7:0]          best_idx_r,    best_idx_nxt;

  // Shared multiplier for the backdrop luminance sum.
  logic [7:0]        chan_code;
  logic [12:0]       chan_coef;
  logic [SUM_W-1:0]  product;
  logic [SUM_W-1:0]  acc_sum;

  // Reciprocal divide by 10000.
  logic [29:0]       div_in;
  logic [60:0]       recip_prod;

  // Candidate evaluation.
  logic [23:0]       cand_rgb;
  logic [LUMA_W-1:0] cand_luma;
  logic              cand_pass;
  logic [7:0]        ad_r, ad_g, ad_b;
  logic [DIST_W-1:0] cand_dist;

  logic              in_accept;

  assign in_accept = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.palette_index = out_idx_r;

  always_comb begin
    unique case (ch_r)
      2'd0: begin
        chan_code = backdrop_r[23:16];
        chan_coef = COEF_R;
      end
      2'd1: begin
        chan_code = backdrop_r[15:8];
        chan_coef = COEF_G;
      end
      default: begin
        chan_code = backdrop_r[7:0];
        chan_coef = COEF_B;
      end
    endcase
  end

  assign product = SUM_W'(LIN_TAB[chan_code]) * SUM_W'(chan_coef);
  assign acc_sum = acc_r + product;

  // The rounded sum is below 2^34, so the shifted dividend fits in 30 bits.
  assign div_in     = num_r[SUM_W-1:DIV_SHIFT];
  assign recip_prod = {31'd0, div_in} * {30'd0, RECIP_625};

  assign cand_rgb  = SLOT_RGB[idx_r];
  assign cand_luma = SLOT_LUMA[idx_r];
  // After the divide, num_r holds the backdrop luminance.
  assign cand_pass = fg_r ? contrast_ok(cand_luma, num_r[LUMA_W-1:0]) : SLOT_BG_OK[idx_r];

  assign ad_r = (target_r[23:16] >= cand_rgb[23:16]) ? target_r[23:16] - cand_rgb[23:16]
                                                      : cand_rgb[23:16] - target_r[23:16];
  assign ad_g = (target_r[15:8] >= cand_rgb[15:8]) ? target_r[15:8] - cand_rgb[15:8]
                                                    : cand_rgb[15:8] - target_r[15:8];
  assign ad_b = (target_r[7:0] >= cand_rgb[7:0]) ? target_r[7:0] - cand_rgb[7:0]
                                                  : cand_rgb[7:0] - target_r[7:0];
  assign cand_dist = DIST_W'(16'(ad_r) * 16'(ad_r)) + DIST_W'(16'(ad_g) * 16'(ad_g))
                   + DIST_W'(16'(ad_b) * 16'(ad_b));

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_idx_nxt   = out_idx_r;
    target_nxt    = target_r;
    backdrop_nxt  = backdrop_r;
    fg_nxt        = fg_r;
    ch_nxt        = ch_r;
    acc_nxt       = acc_r;
    num_nxt       = num_r;
    idx_nxt       = idx_r;
    best_cost_nxt = best_cost_r;
    best_idx_nxt  = best_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          target_nxt    = in_chan.target_color;
          backdrop_nxt  = in_chan.backdrop_color;
          fg_nxt        = in_chan.is_foreground;
          ch_nxt        = 2'd0;
          acc_nxt       = '0;
          idx_nxt       = '0;
          best_cost_nxt = '1;
          best_idx_nxt  = '0;
          state_nxt     = in_chan.is_foreground ? ST_ACC : ST_SCAN;
        end
      end
      ST_ACC: begin
        acc_nxt = acc_sum;
        ch_nxt  = ch_r + 2'd1;
        if (ch_r == 2'd2) begin
          num_nxt   = acc_sum + SUM_W'(DIV_ROUND);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // Quotient of the rounded sum by 10000 replaces the sum in num_r.
        num_nxt   = SUM_W'(recip_prod[60:RECIP_SHIFT]);
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // Strict compare keeps the lower slot on equal distance.
        if (cand_pass && (cand_dist < best_cost_r)) begin
          best_cost_nxt = cand_dist;
          best_idx_nxt  = idx_r;
        end
        idx_nxt = idx_r + 8'd1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = best_idx_r + 8'(SLOT_FIRST);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_idx_r   <= out_idx_nxt;
    target_r    <= target_nxt;
    backdrop_r  <= backdrop_nxt;
    fg_r        <= fg_nxt;
    ch_r        <= ch_nxt;
    acc_r       <= acc_nxt;
    num_r       <= num_nxt;
    idx_r       <= idx_nxt;
    best_cost_r <= best_cost_nxt;
    best_idx_r  <= best_idx_nxt;
  end

  // A taken request blocks further requests on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_chan.ready)
    else $error("request accepted while previous one still in progress");

  // The scan index never leaves the palette.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= LAST_IDX))
    else $error("candidate index beyond last palette slot");

  // The best cost can only fall while scanning.
  a_cost_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && ($past(state_r) == ST_SCAN) |-> (best_cost_r <= $past(best_cost_r)))
    else $error("best distance increased during scan");

  // A result slot is never one of the sixteen system colors.
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.palette_index >= 8'(SLOT_FIRST)))
    else $error("result slot below 16");

  // The divide always finishes into the scan.
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (state_r == ST_SCAN))
    else $error("divider did not hand over to the scan");

endmodule

// ----- tb/xterm256_contrast_quantizer_test.sv -----
// Self-checking testbench for the contrast-aware 256-color palette quantizer.
`timescale 1ns / 1ps

module xterm256_contrast_quantizer_test;
  import xcq_pkg::SLOT_FIRST;
  import xcq_pkg::GREY_FIRST;

  // One color request as it travels on the input channel.
  typedef struct packed {
    logic [23:0] target;
    logic [23:0] backdrop;
    logic        fg;
  } quant_req_t;

  // A request that has been taken, together with the slot it must produce.
  typedef struct packed {
    quant_req_t  req;
    logic [7:0]  slot;
  } quant_expect_t;

  // How the result side behaves during one phase of its own pattern.
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_CHOPPY,
    RX_BLOCKED
  } rx_mode_t;

  localparam int RANDOM_REQS  = 1250;
  localparam int QUIET_LIMIT  = 10000;  // cycles with no transfer on either channel
  localparam int TAIL_CYCLES  = 400;    // longer than one full request
  localparam int HOLD_AT      = 200;    // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 2000;
  localparam logic [63:0] EPS_Q20 = 64'd52429;
  localparam logic [63:0] ONE_Q20 = 64'd1 << 20;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  xcq_in_if  in_if ();
  xcq_out_if out_if ();

  xterm256_contrast_quantizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Palette model. Every number below is built once at time zero from the
  // sRGB transfer curve in fixed point, so each prediction is a plain scan.
  // ---------------------------------------------------------------------------

  logic [20:0] lin_light [0:255];   // sRGB code to linear light, Q20
  logic [23:0] pal_rgb   [16:255];
  logic [20:0] pal_luma  [16:255];

  // Fifth power in Q30 with every product floored back to Q30.
  function automatic logic [63:0] pow5_q30(input logic [63:0] t);
    logic [63:0] p;
    p = t;
    for (int k = 0; k < 4; k++) begin
      p = (p * t) >> 30;
    end
    return p;
  endfunction

  // Linear light of one channel code. The gamma segment raises
  // (c/255 + 0.055)/1.055 to 2.4 as the square times the fifth root of the square.
  function automatic logic [20:0] srgb_to_linear(input int unsigned c);
    logic [63:0] base;
    logic [63:0] sq;
    logic [63:0] root;
    logic [63:0] trial;
    logic [63:0] prod;
    if (c <= 10) begin
      return 21'((64'(c) * 64'd104857600 + 64'd164730) / 64'd329460);
    end
    base = ((64'(1000 * c + 14025) << 30) + 64'd134512) / 64'd269025;
    sq   = (base * base) >> 30;
    if (sq >= (64'd1 << 30)) begin
      root = 64'd1 << 30;
    end else begin
      root = 64'd0;
      for (int b = 29; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (pow5_q30(trial) <= sq) begin
          root = trial;
        end
      end
    end
    prod = (sq * root) >> 30;
    return 21'((prod + 64'd512) >> 10);
  endfunction

  // Relative luminance in Q20 with rounded weights of 0.2126, 0.7152, 0.0722.
  function automatic logic [20:0] luma_q20(input logic [23:0] rgb);
    logic [63:0] s;
    s = 64'd2126 * 64'(lin_light[rgb[23:16]]) + 64'd7152 * 64'(lin_light[rgb[15:8]])
      + 64'd722 * 64'(lin_light[rgb[7:0]]);
    return 21'((s + 64'd5000) / 64'd10000);
  endfunction

  // True when the two luminances reach a 7:1 contrast ratio.
  function automatic logic reaches_7to1(input logic [20:0] la, input logic [20:0] lb);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = (la >= lb) ? 64'(la) : 64'(lb);
    lo = (la >= lb) ? 64'(lb) : 64'(la);
    return (hi + EPS_Q20) >= 64'd7 * (lo + EPS_Q20);
  endfunction

  function automatic void build_palette_model();
    logic [7:0] lv [0:5];
    logic [7:0] g;
    int unsigned n;
    lv = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};
    for (int c = 0; c < 256; c++) begin
      lin_light[c] = srgb_to_linear(c);
    end
    for (int s = SLOT_FIRST; s < 256; s++) begin
      if (s >= GREY_FIRST) begin
        g = 8'(8 + 10 * (s - GREY_FIRST));
        pal_rgb[s] = {g, g, g};
      end else begin
        n = s - SLOT_FIRST;
        pal_rgb[s] = {lv[n / 36], lv[(n / 6) % 6], lv[n % 6]};
      end
      pal_luma[s] = luma_q20(pal_rgb[s]);
    end
  endfunction

  // Nearest admissible slot for one request. A strict compare keeps the
  // lower slot on equal distance, and slot 16 stands when nothing qualifies.
  function automatic logic [7:0] nearest_contrast_slot(input quant_req_t req);
    logic [20:0] back_luma;
    logic [31:0] best_dist;
    logic [31:0] cand_dist;
    logic [7:0]  best;
    logic        ok;
    int          dr;
    int          dg;
    int          db;
    back_luma = luma_q20(req.backdrop);
    best_dist = 32'hFFFF_FFFF;
    best      = 8'(SLOT_FIRST);
    for (int s = SLOT_FIRST; s < 256; s++) begin
      if (req.fg) begin
        ok = reaches_7to1(pal_luma[s], back_luma);
      end else begin
        ok = reaches_7to1(pal_luma[s], 21'd0) || reaches_7to1(pal_luma[s], 21'(ONE_Q20));
      end
      if (ok) begin
        dr   = int'(req.target[23:16]) - int'(pal_rgb[s][23:16]);
        dg   = int'(req.target[15:8])  - int'(pal_rgb[s][15:8]);
        db   = int'(req.target[7:0])   - int'(pal_rgb[s][7:0]);
        cand_dist = 32'(dr * dr + dg * dg + db * db);
        if (cand_dist < best_dist) begin
          best_dist = cand_dist;
          best      = 8'(s);
        end
      end
    end
    return best;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------------

  quant_req_t    pending_reqs[$];
  quant_expect_t expected_slots[$];

  function automatic void queue_req(input logic [23:0] target, input logic [23:0] backdrop,
                                    input logic fg);
    quant_req_t r;
    r.target   = target;
    r.backdrop = backdrop;
    r.fg       = fg;
    pending_reqs.push_back(r);
  endfunction

  // A channel code close to one of the cube levels, so that targets land on
  // and around palette entries where distances are close to tied.
  function automatic logic [7:0] near_cube_level();
    int lv [0:5];
    int v;
    lv = '{0, 95, 135, 175, 215, 255};
    v  = lv[$urandom_range(0, 5)] + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic void queue_random_req();
    logic [23:0] target;
    logic [23:0] backdrop;
    logic [7:0]  g;
    logic        fg;
    fg = ($urandom_range(0, 9) < 6);
    case ($urandom_range(0, 4))
      0, 1: target = 24'($urandom_range(0, 24'hFFFFFF));
      2: target = {near_cube_level(), near_cube_level(), near_cube_level()};
      3: begin
        g = 8'($urandom_range(0, 255));
        target = {g, g, g};
      end
      default: target = 24'($urandom());
    endcase
    // Foreground requests only find candidates against a fairly dark or
    // fairly light backdrop, so most backdrops are drawn from those bands.
    case ($urandom_range(0, 9))
      0, 1, 2, 3: backdrop = 24'($urandom());
      4, 5, 6: begin
        backdrop = {8'($urandom_range(0, 60)), 8'($urandom_range(0, 60)),
                    8'($urandom_range(0, 60))};
      end
      7, 8: begin
        backdrop = {8'($urandom_range(180, 255)), 8'($urandom_range(180, 255)),
                    8'($urandom_range(180, 255))};
      end
      default: backdrop = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
    endcase
    queue_req(target, backdrop, fg);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. It offers items in bursts of random length separated by
  // random gaps, and holds an offered item until the monitor reports that it
  // was taken at the previous rising edge.
  // ---------------------------------------------------------------------------

  logic       req_taken = 1'b0;
  quant_req_t next_req;
  int         burst_left = 1;
  int         gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !req_taken) begin
      // The offered request is still waiting for the block; keep it steady.
    end else if (gap_left != 0) begin
      in_if.valid <= 1'b0;
      gap_left--;
    end else if (pending_reqs.size() != 0) begin
      next_req = pending_reqs.pop_front();
      in_if.valid          <= 1'b1;
      in_if.target_color   <= next_req.target;
      in_if.backdrop_color <= next_req.backdrop;
      in_if.is_foreground  <= next_req.fg;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 6);
        // Mostly short gaps; now and then a long one, so the next request
        // shows up at a different point of the block's scan.
        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 350)
                                               : $urandom_range(0, 6);
      end else begin
        burst_left--;
      end
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver. It cycles through phases of steady acceptance, random
  // stalls and blocked stretches. Once, after HOLD_AT results, it holds off
  // for HOLD_CYCLES so the block ends up with a result waiting in its output
  // register, a second one finished behind it, and its input not ready.
  // ---------------------------------------------------------------------------

  int       results_seen = 0;
  rx_mode_t rx_mode = RX_STEADY;
  int       rx_phase_left = 0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      out_if.ready <= 1'b0;
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
    end else begin
      if (rx_phase_left == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            rx_mode = RX_STEADY;
            rx_phase_left = $urandom_range(50, 800);
          end
          1: begin
            rx_mode = RX_CHOPPY;
            rx_phase_left = $urandom_range(50, 800);
          end
          default: begin
            rx_mode = RX_BLOCKED;
            rx_phase_left = $urandom_range(10, 400);
          end
        endcase
      end
      rx_phase_left--;
      case (rx_mode)
        RX_STEADY:  out_if.ready <= 1'b1;
        RX_CHOPPY:  out_if.ready <= ($urandom_range(0, 3) != 0);
        default:    out_if.ready <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. At each rising edge a taken request gets its predicted slot
  // queued, and a taken result is checked against the oldest prediction.
  // ---------------------------------------------------------------------------

  int            mismatches = 0;
  int            quiet_cycles = 0;
  quant_req_t    seen_req;
  quant_expect_t oldest;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      req_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        seen_req.target   = in_if.target_color;
        seen_req.backdrop = in_if.backdrop_color;
        seen_req.fg       = in_if.is_foreground;
        oldest.req  = seen_req;
        oldest.slot = nearest_contrast_slot(seen_req);
        expected_slots.push_back(oldest);
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_slots.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected palette index %0d with no request outstanding",
                     out_if.palette_index);
          end
          mismatches++;
        end else begin
          oldest = expected_slots.pop_front();
          if (out_if.palette_index !== oldest.slot) begin
            if (mismatches < 10) begin
              $display({"palette index mismatch: target %06h backdrop %06h fg %0b",
                        " expected %0d got %0d"},
                       oldest.req.target, oldest.req.backdrop, oldest.req.fg,
                       oldest.slot, out_if.palette_index);
            end
            mismatches++;
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence: directed corners, then random requests, then drain.
  // ---------------------------------------------------------------------------

  logic timed_out = 1'b0;

  initial begin
    in_if.valid          = 1'b0;
    in_if.target_color   = '0;
    in_if.backdrop_color = '0;
    in_if.is_foreground  = 1'b0;
    out_if.ready         = 1'b0;
    build_palette_model();

    // Extremes of both colors under both rules.
    queue_req(24'h000000, 24'h000000, 1'b0);
    queue_req(24'hFFFFFF, 24'hFFFFFF, 1'b0);
    queue_req(24'h000000, 24'hFFFFFF, 1'b1);
    queue_req(24'hFFFFFF, 24'h000000, 1'b1);
    queue_req(24'hFFFFFF, 24'hFFFFFF, 1'b1);
    queue_req(24'h000000, 24'h000000, 1'b1);
    // A mid-grey backdrop leaves no foreground candidate, so slot 16 results.
    queue_req(24'h808080, 24'h777777, 1'b1);
    queue_req(24'hFFFFFF, 24'h767676, 1'b1);
    // Under the background rule the backdrop must have no effect.
    queue_req(24'h808080, 24'h000000, 1'b0);
    queue_req(24'h808080, 24'hFFFFFF, 1'b0);
    // Targets exactly on cube and grey entries.
    queue_req(24'h5F87AF, 24'h123456, 1'b0);
    queue_req(24'h5F87AF, 24'h000000, 1'b1);
    queue_req(24'h080808, 24'hFFFFFF, 1'b0);
    queue_req(24'hEEEEEE, 24'h000000, 1'b1);
    // Equal distances: the lower slot must be kept.
    queue_req(24'h0D0D0D, 24'hFFFFFF, 1'b0);
    queue_req(24'h0D0D0D, 24'hFFFFFF, 1'b1);
    queue_req(24'h730000, 24'hA0A0A0, 1'b0);
    // Pure primaries and alternating bit patterns.
    queue_req(24'hFF0000, 24'h000000, 1'b1);
    queue_req(24'h00FF00, 24'hFFFFFF, 1'b1);
    queue_req(24'h0000FF, 24'h000000, 1'b1);
    queue_req(24'hAAAAAA, 24'h555555, 1'b1);
    queue_req(24'h555555, 24'hAAAAAA, 1'b0);
    for (int i = 0; i < RANDOM_REQS; i++) begin
      queue_random_req();
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every request has been taken and every result checked.
    while (!timed_out && (pending_reqs.size() != 0 || in_if.valid
                          || expected_slots.size() != 0)) begin
      @(posedge clk);
      if (quiet_cycles >= QUIET_LIMIT) begin
        timed_out = 1'b1;
      end
    end
    // Any stray result in this window is flagged by the monitor.
    if (!timed_out) begin
      repeat (TAIL_CYCLES) @(posedge clk);
    end

    if (!timed_out && mismatches == 0) begin
      $display("xterm256_contrast_quantizer_test: PASS");
    end else begin
      $display("xterm256_contrast_quantizer_test: FAIL");
    end
    $finish;
  end

endmodule
